[hw/rtl/bl3_pkg.sv]
`timescale 1ns / 1ps

package bl3_pkg;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

endpackage

[hw/rtl/bl3_if.sv]
`timescale 1ns / 1ps

interface bl3_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;

  modport source (
    output valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
    output ready
  );
endinterface

interface bl3_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last;

  modport source (
    output valid, point_x, point_y, point_z, last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, last,
    output ready
  );
endinterface

[hw/rtl/bresenham_line_3d.sv]
`timescale 1ns / 1ps

// 3D Bresenham line walker.
// in_ch carries items: mode 0 loads a segment (start and end points), mode 1
// asks for the next point. Loads give nothing; a step while a segment is live
// gives one point on out_ch, the segment end flagged with last. The start
// point is never given, and a step while idle is dropped.
// The walk state is updated as the item is taken, and the point lands in the
// output register on the same edge; one item per cycle is sustained while the
// receiver takes points. A single step adder chain lies between the walk
// registers and the output register.
// in_ch.ready is high while the output register is empty or being emptied,
// so a stalled receiver holds off the sender only once a point is waiting;
// the point holds until taken.
// Reset (rst_n low, synchronous) empties the output register and leaves the
// walker idle; steps are ignored until the next load.

module bresenham_line_3d #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bl3_in_if.sink    in_ch,
  bl3_out_if.source out_ch
);

  localparam int EB = COORD_BITS + 3;

  logic [2:0][COORD_BITS-1:0] cur_r;
  logic [2:0][COORD_BITS-1:0] delta_r;
  logic [2:0]                 signs_r;
  bl3_pkg::axis_t             major_r;
  logic [COORD_BITS-1:0]      major_end_r;
  logic signed [EB-1:0]       err_a_r;
  logic signed [EB-1:0]       err_b_r;
  logic                       active_r;

  logic                       out_valid_r;
  logic [COORD_BITS-1:0]      out_x_r;
  logic [COORD_BITS-1:0]      out_y_r;
  logic [COORD_BITS-1:0]      out_z_r;
  logic                       out_last_r;

  logic in_fire;
  logic step_req;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign step_req    = (in_ch.mode == bl3_pkg::MODE_STEP);

  // load set-up
  logic [2:0][COORD_BITS-1:0] st_l;
  logic [2:0][COORD_BITS-1:0] en_l;
  logic [2:0][COORD_BITS:0]   diff_l;
  logic [2:0][COORD_BITS-1:0] dlt_l;
  logic [2:0]                 signs_l;
  bl3_pkg::axis_t             major_l;
  logic [COORD_BITS-1:0]      dmaj_l;
  logic [COORD_BITS-1:0]      da_l;
  logic [COORD_BITS-1:0]      db_l;
  logic [COORD_BITS-1:0]      major_end_l;
  logic signed [EB-1:0]       err_a_l;
  logic signed [EB-1:0]       err_b_l;

  assign st_l[0] = in_ch.start_x;
  assign st_l[1] = in_ch.start_y;
  assign st_l[2] = in_ch.start_z;
  assign en_l[0] = in_ch.end_x;
  assign en_l[1] = in_ch.end_y;
  assign en_l[2] = in_ch.end_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_l[i]  = {en_l[i][COORD_BITS-1], en_l[i]} - {st_l[i][COORD_BITS-1], st_l[i]};
      signs_l[i] = !diff_l[i][COORD_BITS] && (diff_l[i] != '0);
      dlt_l[i]   = diff_l[i][COORD_BITS] ? COORD_BITS'(-diff_l[i]) : diff_l[i][COORD_BITS-1:0];
    end
    if (dlt_l[0] >= dlt_l[1] && dlt_l[0] >= dlt_l[2]) begin
      major_l = bl3_pkg::AXIS_X;
    end else if (dlt_l[1] >= dlt_l[2]) begin
      major_l = bl3_pkg::AXIS_Y;
    end else begin
      major_l = bl3_pkg::AXIS_Z;
    end
    case (major_l)
      bl3_pkg::AXIS_X: begin
        dmaj_l = dlt_l[0]; da_l = dlt_l[1]; db_l = dlt_l[2]; major_end_l = en_l[0];
      end
      bl3_pkg::AXIS_Y: begin
        dmaj_l = dlt_l[1]; da_l = dlt_l[0]; db_l = dlt_l[2]; major_end_l = en_l[1];
      end
      default: begin
        dmaj_l = dlt_l[2]; da_l = dlt_l[1]; db_l = dlt_l[0]; major_end_l = en_l[2];
      end
    endcase
    err_a_l = $signed({2'b00, da_l, 1'b0}) - $signed({3'b000, dmaj_l});
    err_b_l = $signed({2'b00, db_l, 1'b0}) - $signed({3'b000, dmaj_l});
  end

  // one step
  logic [COORD_BITS-1:0]      dmaj_s;
  logic [COORD_BITS-1:0]      da_s;
  logic [COORD_BITS-1:0]      db_s;
  logic [2:0]                 is_maj;
  logic [2:0]                 is_a;
  logic [2:0]                 is_b;
  logic                       go_a;
  logic                       go_b;
  logic [2:0][COORD_BITS-1:0] cur_s;
  logic signed [EB-1:0]       err_a_s;
  logic signed [EB-1:0]       err_b_s;
  logic [COORD_BITS-1:0]      maj_pos_s;
  logic                       last_s;

  always_comb begin
    case (major_r)
      bl3_pkg::AXIS_X: begin
        dmaj_s = delta_r[0]; da_s = delta_r[1]; db_s = delta_r[2];
        is_maj = 3'b001; is_a = 3'b010; is_b = 3'b100;
      end
      bl3_pkg::AXIS_Y: begin
        dmaj_s = delta_r[1]; da_s = delta_r[0]; db_s = delta_r[2];
        is_maj = 3'b010; is_a = 3'b001; is_b = 3'b100;
      end
      default: begin
        dmaj_s = delta_r[2]; da_s = delta_r[1]; db_s = delta_r[0];
        is_maj = 3'b100; is_a = 3'b010; is_b = 3'b001;
      end
    endcase
    go_a = !err_a_r[EB-1];
    go_b = !err_b_r[EB-1];
    for (int i = 0; i < 3; i++) begin
      if (is_maj[i] || (is_a[i] && go_a) || (is_b[i] && go_b)) begin
        cur_s[i] = signs_r[i] ? cur_r[i] + COORD_BITS'(1) : cur_r[i] - COORD_BITS'(1);
      end else begin
        cur_s[i] = cur_r[i];
      end
    end
    err_a_s = err_a_r - (go_a ? $signed({2'b00, dmaj_s, 1'b0}) : $signed(EB'(0)))
              + $signed({2'b00, da_s, 1'b0});
    err_b_s = err_b_r - (go_b ? $signed({2'b00, dmaj_s, 1'b0}) : $signed(EB'(0)))
              + $signed({2'b00, db_s, 1'b0});
    case (major_r)
      bl3_pkg::AXIS_X: maj_pos_s = cur_s[0];
      bl3_pkg::AXIS_Y: maj_pos_s = cur_s[1];
      default:         maj_pos_s = cur_s[2];
    endcase
    last_s = (maj_pos_s == major_end_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (in_fire) begin
      if (!step_req) begin
        active_r <= (dmaj_l != '0);
      end else if (active_r) begin
        active_r <= !last_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      delta_r     <= '0;
      signs_r     <= '0;
      major_r     <= bl3_pkg::AXIS_X;
      major_end_r <= '0;
      err_a_r     <= '0;
      err_b_r     <= '0;
    end else if (in_fire) begin
      if (!step_req) begin
        cur_r       <= st_l;
        delta_r     <= dlt_l;
        signs_r     <= signs_l;
        major_r     <= major_l;
        major_end_r <= major_end_l;
        err_a_r     <= err_a_l;
        err_b_r     <= err_b_l;
      end else if (active_r) begin
        cur_r   <= cur_s;
        err_a_r <= err_a_s;
        err_b_r <= err_b_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && step_req && active_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_req && active_r) begin
      out_x_r    <= cur_s[0];
      out_y_r    <= cur_s[1];
      out_z_r    <= cur_s[2];
      out_last_r <= last_s;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.point_x = out_x_r;
  assign out_ch.point_y = out_y_r;
  assign out_ch.point_z = out_z_r;
  assign out_ch.last    = out_last_r;

  a_step_gives_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_req && active_r) |=> out_valid_r)
    else $error("live step gave no point");

  a_load_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !step_req && out_ch.ready) |=> !out_valid_r)
    else $error("load produced a point");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_req && active_r && last_s) |=> (!active_r && out_last_r))
    else $error("segment end did not idle the walker");

  a_idle_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_req && !active_r) |=> ($stable(cur_r) && !active_r))
    else $error("idle step moved the walker");

endmodule

[sim/bl3_line_checker.sv]
`timescale 1ns / 1ps

module bl3_line_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  bl3_in_if    in_ch,
  bl3_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   loads_seen,
  output int   points_seen,
  output int   idle_steps
);

  localparam int EW = COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EW-1:0]         err_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  point_t                expected_points[$];
  coord_t                pos [3];
  coord_t                major_end;
  bl3_pkg::axis_t        major;
  logic [2:0]            step_up;
  logic [COORD_BITS-1:0] span [3];
  err_t                  err_first;
  err_t                  err_second;
  bit                    walking;

  function automatic err_t widen(logic [COORD_BITS-1:0] v);
    return $signed({3'b000, v});
  endfunction

  function automatic coord_t nudge(coord_t v, logic up);
    return up ? coord_t'(v + 1) : coord_t'(v - 1);
  endfunction

  function automatic int first_minor(bl3_pkg::axis_t m);
    return (m == bl3_pkg::AXIS_Y) ? int'(bl3_pkg::AXIS_X) : int'(bl3_pkg::AXIS_Y);
  endfunction

  function automatic int second_minor(bl3_pkg::axis_t m);
    return (m == bl3_pkg::AXIS_Z) ? int'(bl3_pkg::AXIS_X) : int'(bl3_pkg::AXIS_Z);
  endfunction

  function automatic void compare_field(string name, coord_t want, coord_t got);
    if (got !== want) begin
      errors++;
      $error("%s expected %0d got %0d", name, want, got);
    end
  endfunction

  task automatic clear_walker();
    int i;
    for (i = 0; i < 3; i++) begin
      pos[i]  = '0;
      span[i] = '0;
    end
    major_end  = '0;
    major      = bl3_pkg::AXIS_X;
    step_up    = '0;
    err_first  = '0;
    err_second = '0;
    walking    = 1'b0;
    expected_points.delete();
  endtask

  task automatic load_segment();
    coord_t                tip [3];
    logic signed [COORD_BITS:0] diff;
    int                    i;
    int                    m;
    int                    a;
    int                    b;
    pos[0] = in_ch.start_x;
    pos[1] = in_ch.start_y;
    pos[2] = in_ch.start_z;
    tip[0] = in_ch.end_x;
    tip[1] = in_ch.end_y;
    tip[2] = in_ch.end_z;
    step_up = '0;
    for (i = 0; i < 3; i++) begin
      diff       = tip[i] - pos[i];
      step_up[i] = diff > 0;
      span[i]    = COORD_BITS'((diff < 0) ? -diff : diff);
    end
    if (span[0] >= span[1] && span[0] >= span[2]) major = bl3_pkg::AXIS_X;
    else if (span[1] >= span[2]) major = bl3_pkg::AXIS_Y;
    else major = bl3_pkg::AXIS_Z;
    m = int'(major);
    a = first_minor(major);
    b = second_minor(major);
    major_end  = tip[m];
    err_first  = err_t'(2 * widen(span[a]) - widen(span[m]));
    err_second = err_t'(2 * widen(span[b]) - widen(span[m]));
    walking    = pos[m] != major_end;
    loads_seen++;
  endtask

  task automatic advance_point();
    point_t pt;
    int     m;
    int     a;
    int     b;
    if (!walking) begin
      idle_steps++;
    end else begin
      m = int'(major);
      a = first_minor(major);
      b = second_minor(major);
      pos[m] = nudge(pos[m], step_up[m]);
      if (err_first >= 0) begin
        pos[a]    = nudge(pos[a], step_up[a]);
        err_first = err_t'(err_first - 2 * widen(span[m]));
      end
      if (err_second >= 0) begin
        pos[b]     = nudge(pos[b], step_up[b]);
        err_second = err_t'(err_second - 2 * widen(span[m]));
      end
      err_first  = err_t'(err_first + 2 * widen(span[a]));
      err_second = err_t'(err_second + 2 * widen(span[b]));
      pt.x    = pos[0];
      pt.y    = pos[1];
      pt.z    = pos[2];
      pt.last = pos[m] == major_end;
      if (pt.last) walking = 1'b0;
      expected_points.push_back(pt);
    end
  endtask

  task automatic check_point();
    point_t want;
    if (expected_points.size() == 0) begin
      errors++;
      $error("point (%0d,%0d,%0d) last %0b given with none expected",
             out_ch.point_x, out_ch.point_y, out_ch.point_z, out_ch.last);
    end else begin
      want = expected_points.pop_front();
      points_seen++;
      compare_field("point_x", want.x, out_ch.point_x);
      compare_field("point_y", want.y, out_ch.point_y);
      compare_field("point_z", want.z, out_ch.point_z);
      compare_field("last", coord_t'(want.last), coord_t'(out_ch.last));
    end
  endtask

  // outputs first: a point taken at this edge always predates the item taken with it
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_walker();
    end else begin
      if (out_ch.valid && out_ch.ready) check_point();
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == bl3_pkg::MODE_LOAD) load_segment();
        else advance_point();
      end
    end
    pending = expected_points.size();
  end

endmodule

[sim/tb_bresenham_line_3d.sv]
`timescale 1ns / 1ps

module tb_bresenham_line_3d;

  localparam int CB          = 16;
  localparam int ITEM_TARGET = 1900;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_LIMIT = 2000;

  typedef logic signed [CB-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n;

  bl3_in_if  #(.COORD_BITS(CB)) in_ch ();
  bl3_out_if #(.COORD_BITS(CB)) out_ch ();

  int chk_errors;
  int chk_pending;
  int chk_loads;
  int chk_points;
  int chk_idle;

  int useful;
  int src_gap_pct;
  int quiet_cycles;
  bit calm;
  bit hold_req;
  bit hold_armed;

  bresenham_line_3d #(.COORD_BITS(CB)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bl3_line_checker #(.COORD_BITS(CB)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (chk_errors),
    .pending     (chk_pending),
    .loads_seen  (chk_loads),
    .points_seen (chk_points),
    .idle_steps  (chk_idle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_level();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 5;
      default: return 30;
    endcase
  endfunction

  task automatic offer(bl3_pkg::mode_t md, coord_t sx, coord_t sy, coord_t sz,
                       coord_t ex, coord_t ey, coord_t ez);
    int n;
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= md;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.start_z <= sz;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    in_ch.end_z   <= ez;
    @(posedge clk iff in_ch.ready);
    if (!calm && $urandom_range(1, 100) <= src_gap_pct) begin
      in_ch.valid <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load_item(int sx, int sy, int sz, int ex, int ey, int ez);
    offer(bl3_pkg::MODE_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(sz),
          coord_t'(ex), coord_t'(ey), coord_t'(ez));
  endtask

  // step payload is don't-care, so it is kept random
  task automatic step_item();
    offer(bl3_pkg::MODE_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic random_segment();
    int s [3];
    int e [3];
    int i;
    int kind;
    int reach;
    int gap;
    int len;
    int steps;
    int extra;
    kind  = $urandom_range(0, 99);
    len   = 0;
    reach = 0;
    for (i = 0; i < 3; i++) begin
      s[i] = int'($urandom_range(0, 65535)) - 32768;
      if (kind < 88) begin
        // low kinds share one reach on every axis to provoke major-axis ties
        if (i == 0 || kind >= 10)
          reach = (kind < 70) ? $urandom_range(0, 12) : $urandom_range(0, 60);
        e[i] = ($urandom_range(0, 1) != 0) ? s[i] + reach : s[i] - reach;
        if (e[i] > 32767 || e[i] < -32768) e[i] = 2 * s[i] - e[i];
      end else begin
        e[i] = int'($urandom_range(0, 65535)) - 32768;
      end
      gap = (e[i] > s[i]) ? e[i] - s[i] : s[i] - e[i];
      if (gap > len) len = gap;
    end
    if (kind >= 88) steps = $urandom_range(1, 8);
    else if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, len);
    else steps = len;
    extra = (steps == len && $urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    load_item(s[0], s[1], s[2], e[0], e[1], e[2]);
    useful++;
    repeat (steps) begin
      step_item();
      useful++;
    end
    repeat (extra) step_item();
  endtask

  // receiver: random stall bursts, plus one long hold when asked
  initial begin : sink_side
    int level;
    int tick;
    int n;
    bit held;
    out_ch.ready <= 1'b1;
    level = 0;
    tick  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (tick % 50 == 0) level = pick_level();
      tick++;
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(1, 100) <= level) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int segs;
    int n;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= bl3_pkg::MODE_LOAD;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.start_z <= '0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;
    in_ch.end_z   <= '0;
    rst_n         <= 1'b0;
    useful      = 0;
    src_gap_pct = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    hold_armed  = 1'b0;
    segs        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // idle step, zero-length segment, all-negative tie, y/z tie, z-major
    step_item();
    load_item(7, -7, 100, 7, -7, 100);
    step_item();
    load_item(0, 0, 0, -3, -3, -3);
    repeat (3) step_item();
    load_item(10, 0, 0, 11, 4, -4);
    repeat (4) step_item();
    load_item(0, 0, 0, 2, -1, 5);
    repeat (5) step_item();
    // full-range span, cut short by a reload that walks onto the limits
    load_item(-32768, 32767, -32768, 32767, -32768, 32767);
    repeat (2) step_item();
    load_item(32765, -32766, 0, 32767, -32768, 0);
    repeat (3) step_item();

    while (useful < ITEM_TARGET) begin
      if (segs % 15 == 0) src_gap_pct = pick_level();
      if (!hold_armed && useful >= ITEM_TARGET / 2) begin
        hold_armed = 1'b1;
        hold_req   = 1'b1;
      end
      if (useful >= ITEM_TARGET - 150) calm = 1'b1;
      random_segment();
      segs++;
    end
    in_ch.valid <= 1'b0;

    n = 0;
    @(negedge clk);
    while (chk_pending != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (8) @(negedge clk);

    $display("Run covered %0d segment loads and %0d checked points over %0d segments;",
             chk_loads, chk_points, segs);
    $display("%0d steps arrived with no segment live, with one long receiver hold.",
             chk_idle);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
